[rtl/tsfl_pkg.sv]
package tsfl_pkg;

  localparam int PAGES_PER_SECTOR = 16;
  localparam int IDX_W            = $clog2(PAGES_PER_SECTOR) + 1;
  localparam int PAGE_W           = 4;
  localparam int TGT_W            = 7;
  localparam int TGT_BYTE_W       = 8;
  localparam int TAG_W            = 64;
  localparam int OUT_IDX_W        = 5;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;

  localparam logic [TAG_W-1:0] LOG_TAG = 64'hAAAA_AAAA_AAAA_AAAA;

  // Page index of a sector, -1 when no page has been written.
  typedef logic signed [IDX_W-1:0] idx_t;

  localparam idx_t NO_PAGE  = idx_t'(-1);
  localparam idx_t LAST_IDX = idx_t'(PAGES_PER_SECTOR - 1);

  typedef enum logic [1:0] {
    REQ_SCAN   = 2'd0,
    REQ_FINISH = 2'd1,
    REQ_WRITE  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    LOAD_NONE   = 2'd0,
    LOAD_FIRST  = 2'd1,
    LOAD_SECOND = 2'd2
  } load_t;

  typedef enum logic [1:0] {
    BOOT_INVALID = 2'd0,
    BOOT_FIRST   = 2'd1,
    BOOT_SECOND  = 2'd2,
    BOOT_BOTH    = 2'd3
  } boot_t;

  localparam logic [APB_AW-1:0] ADDR_EXPECTED_TARGETS = 3'h0;

  // Next page to program, wrapping at the end of the sector.
  function automatic idx_t next_page(input idx_t idx);
    idx_t n;
    n = idx + idx_t'(1);
    if (idx == LAST_IDX) begin
      n = '0;
    end
    return n;
  endfunction

  // Low bits of an index as reported on the result channel.
  function automatic logic [OUT_IDX_W-1:0] idx_out(input idx_t idx);
    logic signed [31:0] wide;
    wide = 32'(idx);
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

[rtl/two_sector_flash_log_policy.sv]
// Placement policy for a flash log that keeps one record per page over two
// sectors. Words enter on the in_ channel (valid/ready): scan words report one
// page pair from the highest page down, a finish word ends the boot scan and
// orders repair erases, a write word places a changed record. Every word gives
// exactly one result word on the out_ channel (valid/ready) with program, erase
// and load decisions and both sectors' last written page.
// The word is captured in an input register and decided on the way into the
// output register; one word per cycle is sustained while out_ready stays high.
// The combinational path is the index compare and increment logic between the
// two registers. When the receiver stalls, the output register holds its word
// and the input register takes one more; in_ready drops only when both are
// full. The expected target mask is written over the APB-style port at
// address 0; the user must do so only while no word is in flight, and the
// block itself does not enforce it. pready is always high. A synchronous
// reset (rst_n low) empties both registers, sets both last page indices to
// none, clears the found and record flags and the target mask.
module two_sector_flash_log_policy (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_req_type,
  input  logic [tsfl_pkg::PAGE_W-1:0]        in_page_index,
  input  logic                               in_first_page_erased,
  input  logic                               in_second_page_erased,
  input  logic [tsfl_pkg::TAG_W-1:0]         in_first_page_tag,
  input  logic [tsfl_pkg::TGT_BYTE_W-1:0]    in_first_page_targets,
  input  logic [tsfl_pkg::TAG_W-1:0]         in_second_page_tag,
  input  logic [tsfl_pkg::TGT_BYTE_W-1:0]    in_second_page_targets,
  input  logic                               in_record_differs,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_program_request,
  output logic                               out_program_sector,
  output logic [tsfl_pkg::PAGE_W-1:0]        out_program_page,
  output logic                               out_erase_first,
  output logic                               out_erase_second,
  output logic [1:0]                         out_load_source,
  output logic [1:0]                         out_boot_status,
  output logic signed [tsfl_pkg::OUT_IDX_W-1:0] out_first_last,
  output logic signed [tsfl_pkg::OUT_IDX_W-1:0] out_second_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsfl_pkg::APB_AW-1:0]        paddr,
  input  logic [tsfl_pkg::APB_DW-1:0]        pwdata,
  output logic [tsfl_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  // Configuration register.
  logic [tsfl_pkg::TGT_W-1:0] expected_targets_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_targets_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[tsfl_pkg::APB_AW-1] == 1'b0) begin
      expected_targets_r <= pwdata[tsfl_pkg::TGT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[tsfl_pkg::APB_AW-1] == 1'b0) begin
      prdata = tsfl_pkg::APB_DW'(expected_targets_r);
    end
  end

  // Input register.
  logic                            s0_valid_r;
  logic [1:0]                      s0_req_r;
  logic [tsfl_pkg::PAGE_W-1:0]     s0_page_r;
  logic                            s0_first_erased_r;
  logic                            s0_second_erased_r;
  logic [tsfl_pkg::TAG_W-1:0]      s0_first_tag_r;
  logic [tsfl_pkg::TGT_BYTE_W-1:0] s0_first_tgt_r;
  logic [tsfl_pkg::TAG_W-1:0]      s0_second_tag_r;
  logic [tsfl_pkg::TGT_BYTE_W-1:0] s0_second_tgt_r;
  logic                            s0_differs_r;
  logic                            out_valid_r;
  logic                            advance;

  assign advance  = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_req_r           <= in_req_type;
      s0_page_r          <= in_page_index;
      s0_first_erased_r  <= in_first_page_erased;
      s0_second_erased_r <= in_second_page_erased;
      s0_first_tag_r     <= in_first_page_tag;
      s0_first_tgt_r     <= in_first_page_targets;
      s0_second_tag_r    <= in_second_page_tag;
      s0_second_tgt_r    <= in_second_page_targets;
      s0_differs_r       <= in_record_differs;
    end
  end

  // Policy state.
  tsfl_pkg::idx_t first_last_r, first_last_nxt;
  tsfl_pkg::idx_t second_last_r, second_last_nxt;
  logic first_found_r, first_found_nxt;
  logic second_found_r, second_found_nxt;
  logic first_ok_r, first_ok_nxt;
  logic second_ok_r, second_ok_nxt;

  logic                        prog, psec, er1, er2;
  logic [tsfl_pkg::PAGE_W-1:0] ppage;
  logic [1:0]                  load, status;
  logic                        page_in_range;
  logic                        v1, v2;
  logic                        pair_ok;
  logic signed [tsfl_pkg::IDX_W:0] second_plus_one;
  logic [tsfl_pkg::TGT_BYTE_W-1:0] expected_byte;

  assign page_in_range   = 32'(s0_page_r) < 32'(tsfl_pkg::PAGES_PER_SECTOR);
  assign expected_byte   = tsfl_pkg::TGT_BYTE_W'(expected_targets_r);
  assign second_plus_one = (tsfl_pkg::IDX_W+1)'(second_last_r) + (tsfl_pkg::IDX_W+1)'(1);
  // Consistent pairs: equal indices, first one ahead, or first erased after a
  // full second sector.
  assign pair_ok = (first_last_r == second_last_r) ||
                   ((tsfl_pkg::IDX_W+1)'(first_last_r) == second_plus_one) ||
                   (first_last_r == tsfl_pkg::NO_PAGE &&
                    second_last_r == tsfl_pkg::LAST_IDX);

  always_comb begin
    first_last_nxt   = first_last_r;
    second_last_nxt  = second_last_r;
    first_found_nxt  = first_found_r;
    second_found_nxt = second_found_r;
    first_ok_nxt     = first_ok_r;
    second_ok_nxt    = second_ok_r;
    prog   = 1'b0;
    psec   = 1'b0;
    ppage  = '0;
    er1    = 1'b0;
    er2    = 1'b0;
    load   = tsfl_pkg::LOAD_NONE;
    status = tsfl_pkg::BOOT_INVALID;
    v1     = 1'b0;
    v2     = 1'b0;
    case (s0_req_r)
      tsfl_pkg::REQ_SCAN: begin
        if (page_in_range) begin
          if (!first_found_r && !s0_first_erased_r) begin
            first_found_nxt = 1'b1;
            first_last_nxt  = tsfl_pkg::idx_t'(s0_page_r);
            first_ok_nxt    = (s0_first_tag_r == tsfl_pkg::LOG_TAG) &&
                              (s0_first_tgt_r == expected_byte);
          end
          if (!second_found_r && !s0_second_erased_r) begin
            second_found_nxt = 1'b1;
            second_last_nxt  = tsfl_pkg::idx_t'(s0_page_r);
            second_ok_nxt    = (s0_second_tag_r == tsfl_pkg::LOG_TAG) &&
                               (s0_second_tgt_r == expected_byte);
          end
        end
      end
      tsfl_pkg::REQ_FINISH: begin
        // Repair what an interrupted write or erase can leave behind.
        if (first_last_r == tsfl_pkg::LAST_IDX && second_last_r == tsfl_pkg::LAST_IDX) begin
          er1            = 1'b1;
          first_last_nxt = tsfl_pkg::NO_PAGE;
          first_ok_nxt   = 1'b0;
        end else if (first_last_r == '0 && second_last_r == tsfl_pkg::LAST_IDX) begin
          er2             = 1'b1;
          second_last_nxt = tsfl_pkg::NO_PAGE;
          second_ok_nxt   = 1'b0;
        end else if (!pair_ok) begin
          er1             = 1'b1;
          er2             = 1'b1;
          first_last_nxt  = tsfl_pkg::NO_PAGE;
          second_last_nxt = tsfl_pkg::NO_PAGE;
          first_ok_nxt    = 1'b0;
          second_ok_nxt   = 1'b0;
        end
        v1 = (first_last_nxt != tsfl_pkg::NO_PAGE) && first_ok_nxt;
        v2 = (second_last_nxt != tsfl_pkg::NO_PAGE) && second_ok_nxt;
        if (v1 && v2) begin
          status = tsfl_pkg::BOOT_BOTH;
          load   = (first_last_nxt == second_last_nxt) ? tsfl_pkg::LOAD_SECOND
                                                       : tsfl_pkg::LOAD_FIRST;
        end else if (v1) begin
          status = tsfl_pkg::BOOT_FIRST;
          load   = tsfl_pkg::LOAD_FIRST;
        end else if (v2) begin
          status = tsfl_pkg::BOOT_SECOND;
          load   = (first_last_nxt <= second_last_nxt) ? tsfl_pkg::LOAD_SECOND
                                                       : tsfl_pkg::LOAD_NONE;
        end
        first_found_nxt  = 1'b0;
        second_found_nxt = 1'b0;
      end
      tsfl_pkg::REQ_WRITE: begin
        if (s0_differs_r) begin
          prog = 1'b1;
          if (first_last_r == second_last_r) begin
            first_last_nxt = tsfl_pkg::next_page(first_last_r);
            psec           = 1'b0;
            ppage          = first_last_nxt[tsfl_pkg::PAGE_W-1:0];
            er2            = (second_last_r == tsfl_pkg::LAST_IDX);
          end else begin
            second_last_nxt = tsfl_pkg::next_page(second_last_r);
            psec            = 1'b1;
            ppage           = second_last_nxt[tsfl_pkg::PAGE_W-1:0];
            er1             = (first_last_r == tsfl_pkg::LAST_IDX);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_last_r   <= tsfl_pkg::NO_PAGE;
      second_last_r  <= tsfl_pkg::NO_PAGE;
      first_found_r  <= 1'b0;
      second_found_r <= 1'b0;
      first_ok_r     <= 1'b0;
      second_ok_r    <= 1'b0;
    end else if (advance) begin
      first_last_r   <= first_last_nxt;
      second_last_r  <= second_last_nxt;
      first_found_r  <= first_found_nxt;
      second_found_r <= second_found_nxt;
      first_ok_r     <= first_ok_nxt;
      second_ok_r    <= second_ok_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_program_request <= prog;
      out_program_sector  <= psec;
      out_program_page    <= ppage;
      out_erase_first     <= er1;
      out_erase_second    <= er2;
      out_load_source     <= load;
      out_boot_status     <= status;
      out_first_last      <= tsfl_pkg::idx_out(first_last_nxt);
      out_second_last     <= tsfl_pkg::idx_out(second_last_nxt);
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both registers are held");

  a_program_not_with_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_program_request) |->
      (out_load_source == tsfl_pkg::LOAD_NONE && out_boot_status == tsfl_pkg::BOOT_INVALID))
    else $error("program and boot load reported in one word");

  a_both_valid_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_boot_status == tsfl_pkg::BOOT_BOTH) |->
      out_load_source != tsfl_pkg::LOAD_NONE)
    else $error("both sectors valid but nothing to load");

  a_double_erase_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_erase_first && out_erase_second) |->
      (!out_program_request && out_first_last == '1 && out_second_last == '1))
    else $error("double erase left a page index behind");

  a_finish_clears_found: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s0_req_r == tsfl_pkg::REQ_FINISH) |=> (!first_found_r && !second_found_r))
    else $error("found flags survived a finish word");
`endif

endmodule

[verif/tb_two_sector_flash_log_policy.sv]
module tb_two_sector_flash_log_policy;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_WORDS  = 120;
  // Request code that the block leaves without effect.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                      req;
    logic [tsfl_pkg::PAGE_W-1:0]     page;
    logic                            erased1;
    logic                            erased2;
    logic [tsfl_pkg::TAG_W-1:0]      tag1;
    logic [tsfl_pkg::TGT_BYTE_W-1:0] tgt1;
    logic [tsfl_pkg::TAG_W-1:0]      tag2;
    logic [tsfl_pkg::TGT_BYTE_W-1:0] tgt2;
    logic                            differs;
  } flash_word_t;

  typedef struct {
    logic                                  prog;
    logic                                  psec;
    logic [tsfl_pkg::PAGE_W-1:0]           ppage;
    logic                                  er1;
    logic                                  er2;
    logic [1:0]                            load;
    logic [1:0]                            status;
    logic signed [tsfl_pkg::OUT_IDX_W-1:0] first_last;
    logic signed [tsfl_pkg::OUT_IDX_W-1:0] second_last;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      in_req_type = '0;
  logic [tsfl_pkg::PAGE_W-1:0]     in_page_index = '0;
  logic                            in_first_page_erased = 1'b0;
  logic                            in_second_page_erased = 1'b0;
  logic [tsfl_pkg::TAG_W-1:0]      in_first_page_tag = '0;
  logic [tsfl_pkg::TGT_BYTE_W-1:0] in_first_page_targets = '0;
  logic [tsfl_pkg::TAG_W-1:0]      in_second_page_tag = '0;
  logic [tsfl_pkg::TGT_BYTE_W-1:0] in_second_page_targets = '0;
  logic                            in_record_differs = 1'b0;

  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic                                  out_program_request;
  logic                                  out_program_sector;
  logic [tsfl_pkg::PAGE_W-1:0]           out_program_page;
  logic                                  out_erase_first;
  logic                                  out_erase_second;
  logic [1:0]                            out_load_source;
  logic [1:0]                            out_boot_status;
  logic signed [tsfl_pkg::OUT_IDX_W-1:0] out_first_last;
  logic signed [tsfl_pkg::OUT_IDX_W-1:0] out_second_last;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [tsfl_pkg::APB_AW-1:0] paddr = '0;
  logic [tsfl_pkg::APB_DW-1:0] pwdata = '0;
  logic [tsfl_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  two_sector_flash_log_policy uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_page_index         (in_page_index),
    .in_first_page_erased  (in_first_page_erased),
    .in_second_page_erased (in_second_page_erased),
    .in_first_page_tag     (in_first_page_tag),
    .in_first_page_targets (in_first_page_targets),
    .in_second_page_tag    (in_second_page_tag),
    .in_second_page_targets(in_second_page_targets),
    .in_record_differs     (in_record_differs),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_program_request   (out_program_request),
    .out_program_sector    (out_program_sector),
    .out_program_page      (out_program_page),
    .out_erase_first       (out_erase_first),
    .out_erase_second      (out_erase_second),
    .out_load_source       (out_load_source),
    .out_boot_status       (out_boot_status),
    .out_first_last        (out_first_last),
    .out_second_last       (out_second_last),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always #10 clk = ~clk;

  flash_word_t stim_words[$];
  decision_t   expected_decisions[$];
  flash_word_t word_on_bus;

  // Shadow of the policy state and the target mask register.
  tsfl_pkg::idx_t             first_idx = tsfl_pkg::NO_PAGE;
  tsfl_pkg::idx_t             second_idx = tsfl_pkg::NO_PAGE;
  logic                       first_found = 1'b0;
  logic                       second_found = 1'b0;
  logic                       first_ok = 1'b0;
  logic                       second_ok = 1'b0;
  logic [tsfl_pkg::TGT_W-1:0] shadow_targets = '0;

  logic [tsfl_pkg::TGT_W-1:0] cur_targets = '0;
  bit no_idle = 1'b0;
  int mismatches = 0;
  int words_queued = 0;
  int words_sent = 0;
  int results_checked = 0;
  int finish_words = 0;
  int program_orders = 0;
  int erase_orders = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic tsfl_pkg::idx_t advance_page(input tsfl_pkg::idx_t p);
    int n;
    n = int'(p) + 1;
    if (n >= tsfl_pkg::PAGES_PER_SECTOR || n < 0) begin
      return '0;
    end
    return tsfl_pkg::idx_t'(n);
  endfunction

  // Applies one word to the shadow state and returns the decision it causes.
  task automatic decide_word(input flash_word_t w, output decision_t d);
    int i1;
    int i2;
    int last;
    bit v1;
    bit v2;
    last = tsfl_pkg::PAGES_PER_SECTOR - 1;
    d = '{default: '0};
    if (w.req == tsfl_pkg::REQ_SCAN) begin
      if (int'(w.page) < tsfl_pkg::PAGES_PER_SECTOR) begin
        if (!first_found && !w.erased1) begin
          first_found = 1'b1;
          first_idx = tsfl_pkg::idx_t'(w.page);
          first_ok = (w.tag1 == tsfl_pkg::LOG_TAG) && (w.tgt1 == {1'b0, shadow_targets});
        end
        if (!second_found && !w.erased2) begin
          second_found = 1'b1;
          second_idx = tsfl_pkg::idx_t'(w.page);
          second_ok = (w.tag2 == tsfl_pkg::LOG_TAG) && (w.tgt2 == {1'b0, shadow_targets});
        end
      end
    end else if (w.req == tsfl_pkg::REQ_FINISH) begin
      finish_words++;
      i1 = int'(first_idx);
      i2 = int'(second_idx);
      // Power-loss repair: keep only pairs that a sequence of writes can leave.
      if (i1 == last && i2 == last) begin
        d.er1 = 1'b1;
        first_idx = tsfl_pkg::NO_PAGE;
        first_ok = 1'b0;
      end else if (i1 == 0 && i2 == last) begin
        d.er2 = 1'b1;
        second_idx = tsfl_pkg::NO_PAGE;
        second_ok = 1'b0;
      end else if (!(i1 == i2 || i1 == i2 + 1 || (i1 == -1 && i2 == last))) begin
        d.er1 = 1'b1;
        d.er2 = 1'b1;
        first_idx = tsfl_pkg::NO_PAGE;
        second_idx = tsfl_pkg::NO_PAGE;
        first_ok = 1'b0;
        second_ok = 1'b0;
      end
      i1 = int'(first_idx);
      i2 = int'(second_idx);
      v1 = (i1 != -1) && first_ok;
      v2 = (i2 != -1) && second_ok;
      if (v1 && v2) begin
        d.status = tsfl_pkg::BOOT_BOTH;
        d.load = (i1 == i2) ? tsfl_pkg::LOAD_SECOND : tsfl_pkg::LOAD_FIRST;
      end else if (v1) begin
        d.status = tsfl_pkg::BOOT_FIRST;
        d.load = tsfl_pkg::LOAD_FIRST;
      end else if (v2) begin
        d.status = tsfl_pkg::BOOT_SECOND;
        d.load = (i1 <= i2) ? tsfl_pkg::LOAD_SECOND : tsfl_pkg::LOAD_NONE;
      end
      first_found = 1'b0;
      second_found = 1'b0;
    end else if (w.req == tsfl_pkg::REQ_WRITE && w.differs) begin
      program_orders++;
      d.prog = 1'b1;
      if (first_idx == second_idx) begin
        first_idx = advance_page(first_idx);
        d.psec = 1'b0;
        d.ppage = first_idx[tsfl_pkg::PAGE_W-1:0];
        d.er2 = (int'(second_idx) == last);
      end else begin
        second_idx = advance_page(second_idx);
        d.psec = 1'b1;
        d.ppage = second_idx[tsfl_pkg::PAGE_W-1:0];
        d.er1 = (int'(first_idx) == last);
      end
    end
    if (d.er1 || d.er2) begin
      erase_orders++;
    end
    d.first_last = first_idx[tsfl_pkg::OUT_IDX_W-1:0];
    d.second_last = second_idx[tsfl_pkg::OUT_IDX_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("mismatch in %s on result %0d: got %0h, expected %0h",
             what, results_checked, got, want);
  endtask

  // Driver: one word on the bus at a time, with random gaps between some words.
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decision_t d;
        decide_word(word_on_bus, d);
        expected_decisions.push_back(d);
        words_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_words.size() > 0) begin
          word_on_bus = stim_words.pop_front();
          in_req_type <= word_on_bus.req;
          in_page_index <= word_on_bus.page;
          in_first_page_erased <= word_on_bus.erased1;
          in_second_page_erased <= word_on_bus.erased2;
          in_first_page_tag <= word_on_bus.tag1;
          in_first_page_targets <= word_on_bus.tgt1;
          in_second_page_tag <= word_on_bus.tag2;
          in_second_page_targets <= word_on_bus.tgt2;
          in_record_differs <= word_on_bus.differs;
          nv = 1'b1;
          send_gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        end
      end
    end
    in_valid <= nv;
  end

  // Monitor: checks each accepted result and stalls the result side at random.
  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_decisions.size() == 0) begin
          report_mismatch("unexpected result", 8'h1, 8'h0);
        end else begin
          want = expected_decisions.pop_front();
          if (out_program_request !== want.prog)
            report_mismatch("program_request", 8'(out_program_request), 8'(want.prog));
          if (out_program_sector !== want.psec)
            report_mismatch("program_sector", 8'(out_program_sector), 8'(want.psec));
          if (out_program_page !== want.ppage)
            report_mismatch("program_page", 8'(out_program_page), 8'(want.ppage));
          if (out_erase_first !== want.er1)
            report_mismatch("erase_first", 8'(out_erase_first), 8'(want.er1));
          if (out_erase_second !== want.er2)
            report_mismatch("erase_second", 8'(out_erase_second), 8'(want.er2));
          if (out_load_source !== want.load)
            report_mismatch("load_source", 8'(out_load_source), 8'(want.load));
          if (out_boot_status !== want.status)
            report_mismatch("boot_status", 8'(out_boot_status), 8'(want.status));
          if (out_first_last !== want.first_last)
            report_mismatch("first_last", 8'(out_first_last), 8'(want.first_last));
          if (out_second_last !== want.second_last)
            report_mismatch("second_last", 8'(out_second_last), 8'(want.second_last));
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_decisions.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic flash_word_t mk_word(
      input logic [1:0] req, input logic [tsfl_pkg::PAGE_W-1:0] page,
      input logic e1, input logic e2,
      input logic [tsfl_pkg::TAG_W-1:0] t1, input logic [tsfl_pkg::TGT_BYTE_W-1:0] g1,
      input logic [tsfl_pkg::TAG_W-1:0] t2, input logic [tsfl_pkg::TGT_BYTE_W-1:0] g2,
      input logic differs);
    flash_word_t w;
    w.req = req;
    w.page = page;
    w.erased1 = e1;
    w.erased2 = e2;
    w.tag1 = t1;
    w.tgt1 = g1;
    w.tag2 = t2;
    w.tgt2 = g2;
    w.differs = differs;
    return w;
  endfunction

  // Scan word for one page pair.
  function automatic flash_word_t scan_word(
      input logic [tsfl_pkg::PAGE_W-1:0] page,
      input logic e1, input logic [tsfl_pkg::TAG_W-1:0] t1,
      input logic [tsfl_pkg::TGT_BYTE_W-1:0] g1,
      input logic e2, input logic [tsfl_pkg::TAG_W-1:0] t2,
      input logic [tsfl_pkg::TGT_BYTE_W-1:0] g2);
    return mk_word(tsfl_pkg::REQ_SCAN, page, e1, e2, t1, g1, t2, g2, 1'b0);
  endfunction

  // Word that carries only a request code and the record flag.
  function automatic flash_word_t ctrl_word(input logic [1:0] req, input logic differs);
    return mk_word(req, '0, 1'b0, 1'b0, '0, '0, '0, '0, differs);
  endfunction

  task automatic push_word(input flash_word_t w);
    stim_words.push_back(w);
    words_queued++;
  endtask

  task automatic page_content(input bit erased, output logic [tsfl_pkg::TAG_W-1:0] tag,
                              output logic [tsfl_pkg::TGT_BYTE_W-1:0] tgt);
    tag = {$urandom, $urandom};
    tgt = 8'($urandom_range(0, 255));
    if (erased) begin
      if ($urandom_range(0, 3) != 0) begin
        tag = '1;
        tgt = '1;
      end
    end else begin
      if ($urandom_range(0, 4) != 0) tag = tsfl_pkg::LOG_TAG;
      if ($urandom_range(0, 4) != 0) tgt = {1'b0, cur_targets};
    end
  endtask

  function automatic flash_word_t random_word();
    flash_word_t w;
    w.req = 2'($urandom_range(0, 3));
    w.page = tsfl_pkg::PAGE_W'($urandom_range(0, 15));
    w.erased1 = 1'($urandom_range(0, 1));
    w.erased2 = 1'($urandom_range(0, 1));
    w.tag1 = ($urandom_range(0, 2) == 0) ? tsfl_pkg::LOG_TAG : {$urandom, $urandom};
    w.tgt1 = ($urandom_range(0, 2) == 0) ? {1'b0, cur_targets} : 8'($urandom);
    w.tag2 = ($urandom_range(0, 2) == 0) ? tsfl_pkg::LOG_TAG : {$urandom, $urandom};
    w.tgt2 = ($urandom_range(0, 2) == 0) ? {1'b0, cur_targets} : 8'($urandom);
    w.differs = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // A flash picture with last written pages l1 and l2 (-1 for none), scanned
  // from the top down, then the finish word and a run of write requests.
  task automatic queue_boot_and_writes();
    int l1;
    int l2;
    int top;
    int k;
    int n;
    flash_word_t w;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      l1 = $urandom_range(0, 16) - 1;
      l2 = l1;
    end else if (k < 6) begin
      l2 = $urandom_range(0, 15) - 1;
      l1 = l2 + 1;
    end else if (k == 6) begin
      l1 = -1;
      l2 = tsfl_pkg::PAGES_PER_SECTOR - 1;
    end else if (k == 7) begin
      l1 = tsfl_pkg::PAGES_PER_SECTOR - 1;
      l2 = tsfl_pkg::PAGES_PER_SECTOR - 1;
    end else if (k == 8) begin
      l1 = 0;
      l2 = tsfl_pkg::PAGES_PER_SECTOR - 1;
    end else begin
      l1 = $urandom_range(0, 16) - 1;
      l2 = $urandom_range(0, 16) - 1;
    end
    top = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                      : tsfl_pkg::PAGES_PER_SECTOR - 1;
    for (int p = top; p >= 0; p--) begin
      w = random_word();
      w.req = tsfl_pkg::REQ_SCAN;
      w.page = tsfl_pkg::PAGE_W'(p);
      w.erased1 = (p > l1);
      w.erased2 = (p > l2);
      page_content(w.erased1, w.tag1, w.tgt1);
      page_content(w.erased2, w.tag2, w.tgt2);
      push_word(w);
      if (p <= l1 && p <= l2 && $urandom_range(0, 1) == 0) break;
    end
    w = random_word();
    w.req = tsfl_pkg::REQ_FINISH;
    push_word(w);
    n = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) begin
      w = random_word();
      w.req = tsfl_pkg::REQ_WRITE;
      w.differs = ($urandom_range(0, 6) != 0);
      push_word(w);
    end
  endtask

  task automatic wait_idle();
    while (stim_words.size() > 0 || in_valid || expected_decisions.size() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_targets(input logic [tsfl_pkg::TGT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tsfl_pkg::ADDR_EXPECTED_TARGETS;
    pwdata <= tsfl_pkg::APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_targets = value;
    cur_targets = value;
  endtask

  initial begin
    logic [tsfl_pkg::TGT_W-1:0] phase_targets[8];
    int phase_start;
    phase_targets = '{7'h7F, 7'h00, 7'($urandom), 7'h7F,
                      7'($urandom), 7'($urandom), 7'h00, 7'($urandom)};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the target mask at its reset value of zero.
    push_word(mk_word(REQ_UNUSED, 4'hF, 1'b1, 1'b1, '1, 8'hFF, '1, 8'hFF, 1'b1));
    push_word(ctrl_word(tsfl_pkg::REQ_WRITE, 1'b0));
    push_word(ctrl_word(tsfl_pkg::REQ_FINISH, 1'b0));
    push_word(scan_word(4'd15, 1'b1, '1, 8'hFF, 1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(scan_word(4'd14, 1'b0, '0, 8'h00, 1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(scan_word(4'd13, 1'b0, tsfl_pkg::LOG_TAG, 8'h00,
                        1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(ctrl_word(tsfl_pkg::REQ_FINISH, 1'b0));
    push_word(ctrl_word(tsfl_pkg::REQ_WRITE, 1'b1));
    push_word(ctrl_word(tsfl_pkg::REQ_WRITE, 1'b1));
    push_word(scan_word(4'd15, 1'b0, tsfl_pkg::LOG_TAG, 8'h00,
                        1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(ctrl_word(tsfl_pkg::REQ_FINISH, 1'b0));
    push_word(ctrl_word(tsfl_pkg::REQ_WRITE, 1'b1));
    push_word(scan_word(4'd0, 1'b0, tsfl_pkg::LOG_TAG, 8'hFF, 1'b1, '1, 8'hFF));
    push_word(ctrl_word(tsfl_pkg::REQ_FINISH, 1'b0));
    push_word(scan_word(4'd15, 1'b1, '1, 8'hFF, 1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(scan_word(4'd0, 1'b0, tsfl_pkg::LOG_TAG, 8'h00,
                        1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(ctrl_word(tsfl_pkg::REQ_FINISH, 1'b0));
    push_word(scan_word(4'd14, 1'b0, tsfl_pkg::LOG_TAG, 8'h00, 1'b1, '1, 8'hFF));
    push_word(scan_word(4'd13, 1'b0, '1, 8'hFF, 1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(ctrl_word(tsfl_pkg::REQ_FINISH, 1'b0));
    push_word(scan_word(4'd14, 1'b0, tsfl_pkg::LOG_TAG, 8'h00,
                        1'b0, tsfl_pkg::LOG_TAG, 8'h00));
    push_word(ctrl_word(tsfl_pkg::REQ_FINISH, 1'b0));
    // Three writes from (14,14): the third wraps the first sector and erases
    // the full second sector.
    repeat (3) push_word(ctrl_word(tsfl_pkg::REQ_WRITE, 1'b1));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_targets(phase_targets[ph]);
      no_idle = (ph == 2 || ph == 5);
      phase_start = words_queued;
      while (words_queued - phase_start < PHASE_WORDS) begin
        if ($urandom_range(0, 9) < 8) begin
          queue_boot_and_writes();
        end else begin
          repeat ($urandom_range(1, 5)) push_word(random_word());
        end
      end
      // The sender holds off here until every result of the phase is back.
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("sent %0d words over 8 mask settings; %0d results checked",
             words_sent, results_checked);
    $display("%0d finish words, %0d program orders, %0d erase orders",
             finish_words, program_orders, erase_orders);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
